[rtl/u8len_pkg.sv]
package u8len_pkg;

    localparam int DATA_W  = 8;
    localparam int OUT_W   = 16;
    localparam int LIMIT_W = 16;
    localparam int SEQ_W   = 3;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [0:0] REG_LIMIT_ENABLE = 1'b0;
    localparam logic [0:0] REG_CHAR_LIMIT   = 1'b1;

    localparam logic [DATA_W-1:0] MASK_1 = 8'h80;
    localparam logic [DATA_W-1:0] MASK_2 = 8'hE0;
    localparam logic [DATA_W-1:0] MASK_3 = 8'hF0;
    localparam logic [DATA_W-1:0] MASK_4 = 8'hF8;
    localparam logic [DATA_W-1:0] MASK_5 = 8'hFC;
    localparam logic [DATA_W-1:0] MASK_6 = 8'hFE;
    localparam logic [DATA_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [DATA_W-1:0] CONT_CODE = 8'h80;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              last;
    } word_t;

    typedef struct packed {
        logic               limit_enable;
        logic [LIMIT_W-1:0] char_limit;
    } cfg_t;

    // Sequence length from a lead byte; zero for a bad lead byte.
    function automatic logic [SEQ_W-1:0] lead_length(input logic [DATA_W-1:0] b);
        logic [SEQ_W-1:0] len;
        len = 3'd0;
        if ((b & MASK_1) == 8'h00)
            len = 3'd1;
        else if ((b & MASK_2) == 8'hC0)
            len = 3'd2;
        else if ((b & MASK_3) == 8'hE0)
            len = 3'd3;
        else if ((b & MASK_4) == 8'hF0)
            len = 3'd4;
        else if ((b & MASK_5) == 8'hF8)
            len = 3'd5;
        else if ((b & MASK_6) == 8'hFC)
            len = 3'd6;
        return len;
    endfunction

endpackage

[rtl/u8len_byte_if.sv]
interface u8len_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/u8len_result_if.sv]
interface u8len_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_count;
    logic [15:0] byte_count;
    logic        invalid;

    modport source (output valid, output char_count, output byte_count, output invalid,
                    input ready);
    modport sink (input valid, input char_count, input byte_count, input invalid,
                  output ready);
endinterface

[rtl/utf8_sequence_length_counter.sv]
// UTF-8 character counter, legacy 1 to 6 byte sequences.
// Channel "text" carries one string byte per word (data_byte, last_byte);
// channel "result" carries char_count, byte_count and invalid, one word per
// string, issued for the word that has last_byte set.
// Configuration: APB registers limit_enable at 0x0 and char_limit at 0x4;
// write only while no string is in flight. pready is always high.
// Throughput: one byte per cycle while no final byte waits on a stalled result,
// set by the combinational decode and counter update after the input register.
// The final byte passes the input register, then sets the result register.
// A stalled result holds; the block keeps taking bytes of the next string
// until a second final byte reaches the input register, then text.ready drops
// until the result is taken.
// Reset clears the configuration registers, the string state and both valid flags.
module utf8_sequence_length_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    u8len_byte_if.sink                   text,
    u8len_result_if.source               result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8len_pkg::ADDR_W-1:0] paddr,
    input  logic [u8len_pkg::APB_W-1:0]  pwdata,
    output logic [u8len_pkg::APB_W-1:0]  prdata,
    output logic                         pready
);
    import u8len_pkg::*;

    cfg_t  cfg;
    word_t word;
    logic  advance;

    u8len_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    u8len_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .src     (text),
        .advance (advance),
        .word    (word)
    );

    u8len_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .word    (word),
        .cfg     (cfg),
        .advance (advance),
        .result  (result)
    );

endmodule

[rtl/u8len_cfg.sv]
module u8len_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [u8len_pkg::ADDR_W-1:0] paddr,
    input  logic [u8len_pkg::APB_W-1:0]  pwdata,
    output logic [u8len_pkg::APB_W-1:0]  prdata,
    output logic                       pready,
    output u8len_pkg::cfg_t            cfg
);
    import u8len_pkg::*;

    logic               limit_enable_reg;
    logic               limit_enable_next;
    logic [LIMIT_W-1:0] char_limit_reg;
    logic [LIMIT_W-1:0] char_limit_next;
    logic               wr_en;
    logic [0:0]         reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[2:2];

    always_comb
    begin
        limit_enable_next = limit_enable_reg;
        char_limit_next   = char_limit_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_LIMIT_ENABLE: limit_enable_next = pwdata[0];
                REG_CHAR_LIMIT:   char_limit_next   = pwdata[LIMIT_W-1:0];
                default:          limit_enable_next = limit_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_LIMIT_ENABLE: prdata = {{(APB_W-1){1'b0}}, limit_enable_reg};
            REG_CHAR_LIMIT:   prdata = {{(APB_W-LIMIT_W){1'b0}}, char_limit_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_enable_reg <= 1'b0;
            char_limit_reg   <= '0;
        end
        else
        begin
            limit_enable_reg <= limit_enable_next;
            char_limit_reg   <= char_limit_next;
        end
    end

    assign cfg.limit_enable = limit_enable_reg;
    assign cfg.char_limit   = char_limit_reg;

endmodule

[rtl/u8len_in_stage.sv]
module u8len_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    u8len_byte_if.sink         src,
    input  logic               advance,
    output u8len_pkg::word_t   word
);
    import u8len_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;
    logic              take;

    assign src.ready = !valid_reg || advance;
    assign take      = src.valid && src.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= src.data_byte;
            last_reg <= src.last_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;
    assign word.last  = last_reg;

endmodule

[rtl/u8len_core.sv]
module u8len_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  u8len_pkg::word_t  word,
    input  u8len_pkg::cfg_t   cfg,
    output logic              advance,
    u8len_result_if.source    result
);
    import u8len_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [SEQ_W-1:0]       pend_reg, pend_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] chars_reg, chars_next;
    logic [COUNT_WIDTH-1:0] bytes_reg, bytes_next;
    logic                   err_reg, err_next;
    logic                   lim_reg, lim_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       char_out_reg, char_out_next;
    logic [OUT_W-1:0]       byte_out_reg, byte_out_next;
    logic                   inv_out_reg, inv_out_next;

    logic [SEQ_W-1:0]       len;
    logic [SEQ_W-1:0]       fin_seq;
    logic                   finish;
    logic                   at_limit;
    logic [COUNT_WIDTH:0]   chars_sum;
    logic [COUNT_WIDTH:0]   bytes_sum;
    logic [CMP_W-1:0]       chars_ext;
    logic [CMP_W-1:0]       bytes_ext;

    assign advance  = word.valid && (!word.last || !out_valid_reg || result.ready);
    assign len      = lead_length(word.data);
    assign at_limit = cfg.limit_enable &&
                      (CMP_W'(chars_reg) >= CMP_W'(cfg.char_limit));

    always_comb
    begin
        pend_next = pend_reg;
        seq_next  = seq_reg;
        err_next  = err_reg;
        lim_next  = lim_reg;
        finish    = 1'b0;
        fin_seq   = seq_reg;
        if (!err_reg && !lim_reg)
        begin
            if (pend_reg == '0)
            begin
                if (at_limit)
                    lim_next = 1'b1;
                else if (len == '0)
                begin
                    err_next = 1'b1;
                    seq_next = '0;
                end
                else
                begin
                    seq_next  = len;
                    pend_next = len - 3'd1;
                    fin_seq   = len;
                    finish    = (len == 3'd1);
                end
            end
            else if ((word.data & CONT_MASK) != CONT_CODE)
            begin
                err_next  = 1'b1;
                pend_next = '0;
                seq_next  = '0;
            end
            else
            begin
                pend_next = pend_reg - 3'd1;
                finish    = (pend_reg == 3'd1);
            end
        end
        if (finish)
            seq_next = '0;
    end

    assign chars_sum = {1'b0, chars_reg} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign bytes_sum = {1'b0, bytes_reg} + (COUNT_WIDTH+1)'(fin_seq);

    always_comb
    begin
        chars_next = chars_reg;
        bytes_next = bytes_reg;
        if (finish)
        begin
            chars_next = chars_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                : chars_sum[COUNT_WIDTH-1:0];
            bytes_next = bytes_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                : bytes_sum[COUNT_WIDTH-1:0];
        end
    end

    assign chars_ext = CMP_W'(chars_next);
    assign bytes_ext = CMP_W'(bytes_next);

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        char_out_next  = char_out_reg;
        byte_out_next  = byte_out_reg;
        inv_out_next   = inv_out_reg;
        if (advance && word.last)
        begin
            out_valid_next = 1'b1;
            char_out_next  = (chars_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : chars_ext[OUT_W-1:0];
            byte_out_next  = (bytes_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : bytes_ext[OUT_W-1:0];
            inv_out_next   = err_next || (pend_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            seq_reg       <= '0;
            chars_reg     <= '0;
            bytes_reg     <= '0;
            err_reg       <= 1'b0;
            lim_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                if (word.last)
                begin
                    pend_reg  <= '0;
                    seq_reg   <= '0;
                    chars_reg <= '0;
                    bytes_reg <= '0;
                    err_reg   <= 1'b0;
                    lim_reg   <= 1'b0;
                end
                else
                begin
                    pend_reg  <= pend_next;
                    seq_reg   <= seq_next;
                    chars_reg <= chars_next;
                    bytes_reg <= bytes_next;
                    err_reg   <= err_next;
                    lim_reg   <= lim_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_out_reg <= char_out_next;
        byte_out_reg <= byte_out_next;
        inv_out_reg  <= inv_out_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.char_count = char_out_reg;
    assign result.byte_count = byte_out_reg;
    assign result.invalid    = inv_out_reg;

    a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && word.last))
        else $error("result raised without a final word");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && word.last) |=> (pend_reg == '0 && chars_reg == '0 && !err_reg && !lim_reg))
        else $error("string state not cleared after final word");

    a_err_lim_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_reg && lim_reg))
        else $error("error and limit both set");

    a_seq_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (seq_reg > pend_reg))
        else $error("sequence length below pending count");

endmodule

[tb/sv/utf8_sequence_length_counter_tb.sv]
`timescale 1ns / 1ps

module utf8_sequence_length_counter_tb;

    import u8len_pkg::*;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] char_count;
        logic [OUT_W-1:0] byte_count;
        logic             invalid;
    } string_count_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    u8len_byte_if   text_if ();
    u8len_result_if result_if ();

    utf8_sequence_length_counter #(
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    text_word_t    byte_q[$];
    logic [7:0]    str_buf[$];
    string_count_t pending_counts[$];

    bit idle_on = 1'b1;
    int gap_left;
    int stall_left;
    int fail_count;
    text_word_t    next_word;
    string_count_t got_count;
    string_count_t want_count;

    // string decoder state and register shadow
    logic             cfg_en;
    logic [15:0]      cfg_limit;
    logic [2:0]       cont_left;
    logic [2:0]       seq_len;
    logic [CNT_W-1:0] n_chars;
    logic [CNT_W-1:0] n_bytes;
    logic             err_flag;
    logic             stop_flag;

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            8'b111110??: return 3'd5;
            8'b1111110?: return 3'd6;
            default:     return 3'd0;
        endcase
    endfunction

    task automatic clear_string();
        cont_left = '0;
        seq_len   = '0;
        n_chars   = '0;
        n_bytes   = '0;
        err_flag  = 1'b0;
        stop_flag = 1'b0;
    endtask

    task automatic close_char();
        if (n_chars != CNT_MAX)
            n_chars = n_chars + 1'b1;
        if ({1'b0, n_bytes} + seq_len > CNT_MAX)
            n_bytes = CNT_MAX;
        else
            n_bytes = n_bytes + seq_len;
        seq_len = '0;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic l);
        string_count_t r;
        if (!err_flag && !stop_flag)
        begin
            if (cont_left == 0)
            begin
                if (cfg_en && n_chars >= cfg_limit)
                    stop_flag = 1'b1;
                else
                begin
                    seq_len = seq_length(b);
                    if (seq_len == 0)
                        err_flag = 1'b1;
                    else
                    begin
                        cont_left = seq_len - 1'b1;
                        if (cont_left == 0)
                            close_char();
                    end
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                err_flag  = 1'b1;
                cont_left = '0;
                seq_len   = '0;
            end
            else
            begin
                cont_left = cont_left - 1'b1;
                if (cont_left == 0)
                    close_char();
            end
        end
        if (l)
        begin
            if (cont_left != 0)
            begin
                err_flag  = 1'b1;
                cont_left = '0;
                seq_len   = '0;
            end
            r.char_count = (n_chars > OUT_MAX) ? OUT_MAX : n_chars[OUT_W-1:0];
            r.byte_count = (n_bytes > OUT_MAX) ? OUT_MAX : n_bytes[OUT_W-1:0];
            r.invalid    = err_flag;
            pending_counts.push_back(r);
            clear_string();
        end
    endtask

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // text driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
                track_byte(text_if.data_byte, text_if.last_byte);
            if (!text_if.valid || text_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    text_if.valid <= 1'b0;
                end
                else if (idle_on && byte_q.size() != 0 && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(0, 6);
                    text_if.valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    next_word = byte_q.pop_front();
                    text_if.data_byte <= next_word.data;
                    text_if.last_byte <= next_word.last;
                    text_if.valid     <= 1'b1;
                end
                else
                    text_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got_count.char_count = result_if.char_count;
                got_count.byte_count = result_if.byte_count;
                got_count.invalid    = result_if.invalid;
                if (pending_counts.size() == 0)
                    log_failure($sformatf("unexpected result: chars %0d bytes %0d invalid %0b",
                        got_count.char_count, got_count.byte_count, got_count.invalid));
                else
                begin
                    want_count = pending_counts.pop_front();
                    if (want_count.char_count != got_count.char_count
                        || want_count.byte_count != got_count.byte_count
                        || want_count.invalid != got_count.invalid)
                        log_failure($sformatf(
                            "mismatch: expected chars %0d bytes %0d invalid %0b, got chars %0d bytes %0d invalid %0b",
                            want_count.char_count, want_count.byte_count, want_count.invalid,
                            got_count.char_count, got_count.byte_count, got_count.invalid));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [0:0] idx, input logic [APB_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LIMIT_ENABLE)
            cfg_en = val[0];
        else
            cfg_limit = val[15:0];
    endtask

    // mark the final byte and hand the string to the driver
    task automatic flush_string();
        for (int i = 0; i < str_buf.size(); i++)
            byte_q.push_back('{str_buf[i], i == str_buf.size() - 1});
        str_buf.delete();
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || text_if.valid || pending_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] lead_for(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    // mostly well-formed strings, some corrupted, truncated or pure noise
    task automatic random_phase(input int count);
        int made;
        int kind;
        int len;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                repeat ($urandom_range(1, 8)) str_buf.push_back(8'($urandom));
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    len = $urandom_range(1, 6);
                    str_buf.push_back(lead_for(len));
                    repeat (len - 1) str_buf.push_back({2'b10, 6'($urandom)});
                end
                if (kind == 1)
                    str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom);
                if (kind == 2 && str_buf.size() > 1)
                    void'(str_buf.pop_back());
            end
            made += str_buf.size();
            flush_string();
        end
    endtask

    task automatic ascii_run(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back('{8'h41, i == n - 1});
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        text_if.valid     = 1'b0;
        text_if.data_byte = '0;
        text_if.last_byte = 1'b0;
        result_if.ready   = 1'b0;
        fail_count        = 0;
        cfg_en            = 1'b0;
        cfg_limit         = '0;
        clear_string();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every sequence length, bad lead, bad continuation, truncation
        str_buf = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h80, 8'h80, 8'h80,
                    8'hFB, 8'h80, 8'h80, 8'h80, 8'h80,
                    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        flush_string();
        str_buf = '{8'h00, 8'hFF};
        flush_string();
        str_buf = '{8'hE2, 8'h41};
        flush_string();
        str_buf = '{8'hC3};
        flush_string();
        drain();

        // zero limit counts nothing
        cfg_write(REG_CHAR_LIMIT, 32'd0);
        cfg_write(REG_LIMIT_ENABLE, 32'd1);
        @(negedge clk);
        str_buf = '{8'h41, 8'h42};
        flush_string();
        random_phase(50);
        drain();

        // limit stops before a bad lead byte is seen
        cfg_write(REG_CHAR_LIMIT, 32'd2);
        @(negedge clk);
        str_buf = '{8'h41, 8'hC3, 8'hA9, 8'h42, 8'hFF};
        flush_string();
        random_phase(60);
        drain();

        cfg_write(REG_CHAR_LIMIT, 32'($urandom_range(1, 8)));
        @(negedge clk);
        random_phase(60);
        drain();

        // count whole strings, then a wide limit
        cfg_write(REG_LIMIT_ENABLE, 32'd0);
        @(negedge clk);
        random_phase(60);
        ascii_run(20);
        drain();

        cfg_write(REG_CHAR_LIMIT, 32'd65535);
        cfg_write(REG_LIMIT_ENABLE, 32'd1);
        @(negedge clk);
        ascii_run(20);
        random_phase(30);
        drain();

        idle_on = 1'b0;
        cfg_write(REG_CHAR_LIMIT, 32'd5);
        @(negedge clk);
        random_phase(50);
        drain();
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_counts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[utf8_sequence_length_counter.f]
rtl/u8len_pkg.sv
rtl/u8len_byte_if.sv
rtl/u8len_result_if.sv
rtl/u8len_cfg.sv
rtl/u8len_in_stage.sv
rtl/u8len_core.sv
rtl/utf8_sequence_length_counter.sv
tb/sv/utf8_sequence_length_counter_tb.sv
